/* hdl/queue_pair_work_request_engine_assert.svh */
// ---------------------------------------------------------------------------
// queue pair work request engine assertion macros
// the property macros below compile away when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef QUEUE_PAIR_WORK_REQUEST_ENGINE_ASSERT_SVH
`define QUEUE_PAIR_WORK_REQUEST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define QPWRE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qpwre: property failed");
`define QPWRE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("qpwre: forbidden condition seen");
`else
`define QPWRE_ASSERT(lbl, prop)
`define QPWRE_NEVER(lbl, cond)
`endif
`endif

/* hdl/qpwre_pkg.sv */
// ---------------------------------------------------------------------------
// qpwre_pkg
// types, codes and sizes shared by the queue pair work request engine
// ---------------------------------------------------------------------------
package qpwre_pkg;

  localparam int SEND_DEPTH = 16;
  localparam int RECV_DEPTH = 16;

  localparam int SEND_AW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
  localparam int RECV_AW = (RECV_DEPTH > 1) ? $clog2(RECV_DEPTH) : 1;
  localparam int SEND_CW = $clog2(SEND_DEPTH + 1);
  localparam int RECV_CW = $clog2(RECV_DEPTH + 1);
  localparam int SEND_SW = SEND_CW + 1;
  localparam int RECV_SW = RECV_CW + 1;

  localparam int LIMIT_W = 5;
  localparam int CFG_IDX_W = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_LIMIT = 4'd1;

  // command opcodes
  localparam logic [2:0] OP_TO_INIT   = 3'd0;
  localparam logic [2:0] OP_TO_RTR    = 3'd1;
  localparam logic [2:0] OP_TO_RTS    = 3'd2;
  localparam logic [2:0] OP_POST_SEND = 3'd3;
  localparam logic [2:0] OP_POST_RECV = 3'd4;
  localparam logic [2:0] OP_GET_SEND  = 3'd5;
  localparam logic [2:0] OP_GET_RECV  = 3'd6;
  localparam logic [2:0] OP_READ_STAT = 3'd7;

  // operation kinds
  localparam logic [2:0] KIND_SEND      = 3'd0;
  localparam logic [2:0] KIND_RECV      = 3'd1;
  localparam logic [2:0] KIND_READ      = 3'd2;
  localparam logic [2:0] KIND_WRITE     = 3'd3;
  localparam logic [2:0] KIND_CMP_SWAP  = 3'd4;
  localparam logic [2:0] KIND_FETCH_ADD = 3'd5;

  // pair states
  localparam logic [1:0] ST_RESET = 2'd0;
  localparam logic [1:0] ST_INIT  = 2'd1;
  localparam logic [1:0] ST_RTR   = 2'd2;
  localparam logic [1:0] ST_RTS   = 2'd3;

  // result source
  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_SEND = 2'd1;
  localparam logic [1:0] SEL_RECV = 2'd2;

  localparam int STAT_NUM = 9;
  localparam logic [3:0] STAT_ATOMIC_OPS = 4'd8;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] request_id;
    logic [2:0]  operation_kind;
    logic [63:0] local_address;
    logic [31:0] local_mkey;
    logic [63:0] remote_address;
    logic [31:0] remote_mkey;
    logic [31:0] byte_length;
    logic        signaled_flag;
    logic [63:0] compare_or_add;
    logic [63:0] swap_value;
    logic [3:0]  stat_index;
  } qpwre_in_t;

  typedef struct packed {
    logic        accepted;
    logic [63:0] out_request_id;
    logic [2:0]  out_operation_kind;
    logic [63:0] out_local_address;
    logic [31:0] out_local_mkey;
    logic [63:0] out_remote_address;
    logic [31:0] out_remote_mkey;
    logic [31:0] out_byte_length;
    logic        out_signaled;
    logic [63:0] out_compare_or_add;
    logic [63:0] out_swap;
    logic [63:0] stat_value;
  } qpwre_out_t;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] laddr;
    logic [63:0] raddr;
    logic [31:0] lkey;
    logic [31:0] rkey;
    logic [31:0] len;
    logic [2:0]  kind;
    logic        sig;
    logic [63:0] cmp;
    logic [63:0] swp;
  } qpwre_send_ent_t;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] laddr;
    logic [31:0] lkey;
    logic [31:0] len;
  } qpwre_recv_ent_t;

  // control from the decision stage to the usage counters
  typedef struct packed {
    logic        upd;
    logic [2:0]  kind;
    logic [31:0] len;
    logic        ld;
    logic        rd;
    logic [3:0]  idx;
  } qpwre_stat_ctl_t;

endpackage

/* hdl/queue_pair_work_request_engine.sv */
// ---------------------------------------------------------------------------
// queue_pair_work_request_engine
// queue pair front end: state moves, work request posting and popping, stats
// ---------------------------------------------------------------------------
// One command is taken per clock cycle while the result register is not
// stalled: the command sits in an input register, then decode, queue
// pointer update and storage read load the result register. The send and
// receive queues are RAMs with one write and one registered read port. A
// stalled result holds the input register, and input ready drops only
// when both stages are full. No clearing pass is needed after reset.
`include "queue_pair_work_request_engine_assert.svh"

module queue_pair_work_request_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  qpwre_pkg::qpwre_in_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output qpwre_pkg::qpwre_out_t                out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [qpwre_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [qpwre_pkg::LIMIT_W-1:0]        cfg_data_i
);
  import qpwre_pkg::*;

  function automatic logic req_ok(input logic [2:0] kind, input qpwre_in_t r);
    logic base;
    logic remote;
    logic len_nz;
    base   = (r.local_address != '0) && (r.local_mkey != '0);
    remote = (r.remote_address != '0) && (r.remote_mkey != '0);
    len_nz = (r.byte_length != '0);
    case (kind)
      KIND_SEND, KIND_RECV:          req_ok = base && len_nz;
      KIND_READ, KIND_WRITE:         req_ok = base && remote && len_nz;
      KIND_CMP_SWAP, KIND_FETCH_ADD: req_ok = base && remote;
      default:                       req_ok = 1'b0;
    endcase
  endfunction

  // configuration
  logic [LIMIT_W-1:0] send_limit_q, recv_limit_q;

  // pipeline
  logic      s1_valid_q;
  qpwre_in_t s1_q;
  logic      adv;
  logic      out_valid_q;
  logic      res_acc_q, res_acc_d;
  logic [1:0] res_sel_q, res_sel_d;

  // pair and queue state
  logic [1:0]         state_q, state_d;
  logic [SEND_AW-1:0] send_head_q, send_head_d, send_tail;
  logic [SEND_CW-1:0] send_cnt_q, send_cnt_d;
  logic [RECV_AW-1:0] recv_head_q, recv_head_d, recv_tail;
  logic [RECV_CW-1:0] recv_cnt_q, recv_cnt_d;
  logic [SEND_SW-1:0] send_sum;
  logic [RECV_SW-1:0] recv_sum;
  logic send_room, recv_room;
  logic send_push, send_pop, recv_push, recv_pop;
  logic acc;
  logic stat_rd;

  qpwre_send_ent_t send_wr, send_rd;
  qpwre_recv_ent_t recv_wr, recv_rd;
  qpwre_stat_ctl_t stat_ctl;
  logic [63:0]     stat_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_limit_q <= LIMIT_RESET;
      recv_limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SEND_LIMIT) begin
        send_limit_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_RECV_LIMIT) begin
        recv_limit_q <= cfg_data_i;
      end
    end
  end

  // input stage advances whenever the result register is free or drains
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
  end

  // tail slot is head plus count, wrapped once
  always_comb begin
    send_sum  = SEND_SW'(send_head_q) + SEND_SW'(send_cnt_q);
    if (32'(send_sum) >= SEND_DEPTH) begin
      send_sum = send_sum - SEND_SW'(SEND_DEPTH);
    end
    send_tail = send_sum[SEND_AW-1:0];
    recv_sum  = RECV_SW'(recv_head_q) + RECV_SW'(recv_cnt_q);
    if (32'(recv_sum) >= RECV_DEPTH) begin
      recv_sum = recv_sum - RECV_SW'(RECV_DEPTH);
    end
    recv_tail = recv_sum[RECV_AW-1:0];
  end

  assign send_room = (32'(send_cnt_q) < 32'(send_limit_q)) && (32'(send_cnt_q) < SEND_DEPTH);
  assign recv_room = (32'(recv_cnt_q) < 32'(recv_limit_q)) && (32'(recv_cnt_q) < RECV_DEPTH);

  always_comb begin
    state_d   = state_q;
    acc       = 1'b0;
    send_push = 1'b0;
    send_pop  = 1'b0;
    recv_push = 1'b0;
    recv_pop  = 1'b0;
    stat_rd   = 1'b0;
    case (s1_q.opcode)
      OP_TO_INIT: begin
        if (state_q == ST_RESET) begin
          state_d = ST_INIT;
          acc     = 1'b1;
        end
      end
      OP_TO_RTR: begin
        if (state_q == ST_INIT) begin
          state_d = ST_RTR;
          acc     = 1'b1;
        end
      end
      OP_TO_RTS: begin
        if (state_q == ST_RTR) begin
          state_d = ST_RTS;
          acc     = 1'b1;
        end
      end
      OP_POST_SEND: begin
        send_push = (state_q == ST_RTS) && req_ok(s1_q.operation_kind, s1_q) && send_room;
        acc       = send_push;
      end
      OP_POST_RECV: begin
        recv_push = (state_q == ST_RTS) && req_ok(KIND_RECV, s1_q) && recv_room;
        acc       = recv_push;
      end
      OP_GET_SEND: begin
        send_pop = (send_cnt_q != '0);
        acc      = send_pop;
      end
      OP_GET_RECV: begin
        recv_pop = (recv_cnt_q != '0);
        acc      = recv_pop;
      end
      OP_READ_STAT: begin
        stat_rd = (s1_q.stat_index <= STAT_ATOMIC_OPS);
        acc     = stat_rd;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
    if (!adv) begin
      state_d   = state_q;
      send_push = 1'b0;
      send_pop  = 1'b0;
      recv_push = 1'b0;
      recv_pop  = 1'b0;
    end
  end

  always_comb begin
    send_head_d = send_head_q;
    send_cnt_d  = send_cnt_q;
    recv_head_d = recv_head_q;
    recv_cnt_d  = recv_cnt_q;
    if (send_push) begin
      send_cnt_d = send_cnt_q + SEND_CW'(1);
    end
    if (send_pop) begin
      send_cnt_d  = send_cnt_q - SEND_CW'(1);
      send_head_d = (32'(send_head_q) == SEND_DEPTH - 1) ? '0 : send_head_q + SEND_AW'(1);
    end
    if (recv_push) begin
      recv_cnt_d = recv_cnt_q + RECV_CW'(1);
    end
    if (recv_pop) begin
      recv_cnt_d  = recv_cnt_q - RECV_CW'(1);
      recv_head_d = (32'(recv_head_q) == RECV_DEPTH - 1) ? '0 : recv_head_q + RECV_AW'(1);
    end
  end

  always_comb begin
    res_acc_d = acc;
    res_sel_d = send_pop ? SEL_SEND : (recv_pop ? SEL_RECV : SEL_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RESET;
      send_head_q <= '0;
      send_cnt_q  <= '0;
      recv_head_q <= '0;
      recv_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      res_acc_q   <= 1'b0;
      res_sel_q   <= SEL_NONE;
    end else begin
      state_q     <= state_d;
      send_head_q <= send_head_d;
      send_cnt_q  <= send_cnt_d;
      recv_head_q <= recv_head_d;
      recv_cnt_q  <= recv_cnt_d;
      if (adv) begin
        out_valid_q <= 1'b1;
        res_acc_q   <= res_acc_d;
        res_sel_q   <= res_sel_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    send_wr.id    = s1_q.request_id;
    send_wr.laddr = s1_q.local_address;
    send_wr.raddr = s1_q.remote_address;
    send_wr.lkey  = s1_q.local_mkey;
    send_wr.rkey  = s1_q.remote_mkey;
    send_wr.len   = s1_q.byte_length;
    send_wr.kind  = s1_q.operation_kind;
    send_wr.sig   = s1_q.signaled_flag;
    send_wr.cmp   = s1_q.compare_or_add;
    send_wr.swp   = s1_q.swap_value;
    recv_wr.id    = s1_q.request_id;
    recv_wr.laddr = s1_q.local_address;
    recv_wr.lkey  = s1_q.local_mkey;
    recv_wr.len   = s1_q.byte_length;
  end

  qpwre_ram #(
    .WIDTH ($bits(qpwre_send_ent_t)),
    .DEPTH (SEND_DEPTH),
    .AW    (SEND_AW)
  ) u_send_ram (
    .clk_i   (clk_i),
    .we_i    (send_push),
    .waddr_i (send_tail),
    .wdata_i (send_wr),
    .re_i    (send_pop),
    .raddr_i (send_head_q),
    .rdata_o (send_rd)
  );

  qpwre_ram #(
    .WIDTH ($bits(qpwre_recv_ent_t)),
    .DEPTH (RECV_DEPTH),
    .AW    (RECV_AW)
  ) u_recv_ram (
    .clk_i   (clk_i),
    .we_i    (recv_push),
    .waddr_i (recv_tail),
    .wdata_i (recv_wr),
    .re_i    (recv_pop),
    .raddr_i (recv_head_q),
    .rdata_o (recv_rd)
  );

  always_comb begin
    stat_ctl.upd  = send_push || recv_push;
    stat_ctl.kind = recv_push ? KIND_RECV : s1_q.operation_kind;
    stat_ctl.len  = s1_q.byte_length;
    stat_ctl.ld   = adv;
    stat_ctl.rd   = stat_rd;
    stat_ctl.idx  = s1_q.stat_index;
  end

  qpwre_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (stat_ctl),
    .stat_o (stat_value)
  );

  always_comb begin
    out_data_o            = '0;
    out_data_o.accepted   = res_acc_q;
    out_data_o.stat_value = stat_value;
    case (res_sel_q)
      SEL_SEND: begin
        out_data_o.out_request_id     = send_rd.id;
        out_data_o.out_operation_kind = send_rd.kind;
        out_data_o.out_local_address  = send_rd.laddr;
        out_data_o.out_local_mkey     = send_rd.lkey;
        out_data_o.out_remote_address = send_rd.raddr;
        out_data_o.out_remote_mkey    = send_rd.rkey;
        out_data_o.out_byte_length    = send_rd.len;
        out_data_o.out_signaled       = send_rd.sig;
        out_data_o.out_compare_or_add = send_rd.cmp;
        out_data_o.out_swap           = send_rd.swp;
      end
      SEL_RECV: begin
        out_data_o.out_request_id     = recv_rd.id;
        out_data_o.out_operation_kind = KIND_RECV;
        out_data_o.out_local_address  = recv_rd.laddr;
        out_data_o.out_local_mkey     = recv_rd.lkey;
        out_data_o.out_byte_length    = recv_rd.len;
      end
      default: begin
        out_data_o.out_request_id = '0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `QPWRE_NEVER(a_send_cnt_bound, 32'(send_cnt_q) > SEND_DEPTH)
  `QPWRE_NEVER(a_recv_cnt_bound, 32'(recv_cnt_q) > RECV_DEPTH)
  `QPWRE_ASSERT(a_send_push_cnt, send_push |=> send_cnt_q == $past(send_cnt_q) + 1'b1)
  `QPWRE_ASSERT(a_state_step, state_q != $past(state_q) |-> state_q == $past(state_q) + 1'b1)
  `QPWRE_ASSERT(a_pop_is_acc, out_valid_q && res_sel_q != SEL_NONE |-> res_acc_q)

endmodule

/* hdl/qpwre_ram.sv */
// ---------------------------------------------------------------------------
// qpwre_ram
// simple dual port storage, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module qpwre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/qpwre_stats.sv */
// ---------------------------------------------------------------------------
// qpwre_stats
// nine 64-bit usage counters with a registered read port
// ---------------------------------------------------------------------------
module qpwre_stats (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  qpwre_pkg::qpwre_stat_ctl_t ctl_i,
  output logic [63:0]                stat_o
);
  import qpwre_pkg::*;

  logic [63:0] ctr_q [STAT_NUM];
  logic [63:0] ctr_d [STAT_NUM];
  logic [63:0] stat_q;

  always_comb begin
    for (int k = 0; k < STAT_NUM; k++) begin
      ctr_d[k] = ctr_q[k];
    end
    if (ctl_i.upd) begin
      if (!ctl_i.kind[2]) begin
        // ops counters in 0..3, byte counters in 4..7
        ctr_d[{2'b00, ctl_i.kind[1:0]}] = ctr_q[{2'b00, ctl_i.kind[1:0]}] + 64'd1;
        ctr_d[{2'b01, ctl_i.kind[1:0]}] = ctr_q[{2'b01, ctl_i.kind[1:0]}]
                                          + 64'(ctl_i.len);
      end else if (ctl_i.kind == KIND_CMP_SWAP || ctl_i.kind == KIND_FETCH_ADD) begin
        ctr_d[STAT_ATOMIC_OPS] = ctr_q[STAT_ATOMIC_OPS] + 64'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAT_NUM; k++) begin
        ctr_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < STAT_NUM; k++) begin
        ctr_q[k] <= ctr_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld) begin
      stat_q <= ctl_i.rd ? ctr_q[ctl_i.idx] : 64'd0;
    end
  end

  assign stat_o = stat_q;

endmodule

/* tb/queue_pair_work_request_engine_test.sv */
// ---------------------------------------------------------------------------
// queue_pair_work_request_engine_test
// Drives queue pair commands through valid/ready, predicts every response
// from a software copy of the pair state, both work queues and the usage
// counters, and compares each response field by field. Queue limits are
// changed between phases while the engine is idle.
// ---------------------------------------------------------------------------
module queue_pair_work_request_engine_test;
  import qpwre_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int BYTE_STATS = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  qpwre_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  qpwre_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  // predicted engine state
  logic [1:0] qp_state;
  qpwre_send_ent_t sq_ent[SEND_DEPTH];
  qpwre_recv_ent_t rq_ent[RECV_DEPTH];
  int sq_head, sq_cnt, sq_limit;
  int rq_head, rq_cnt, rq_limit;
  logic [63:0] usage_cnt[STAT_NUM];

  qpwre_in_t cmd_backlog[$];
  qpwre_out_t wr_responses[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  queue_pair_work_request_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit request_well_formed(logic [2:0] kind, qpwre_in_t c);
    if (c.local_address == '0 || c.local_mkey == '0) return 1'b0;
    case (kind)
      KIND_SEND, KIND_RECV: return c.byte_length != '0;
      KIND_READ, KIND_WRITE:
        return c.remote_address != '0 && c.remote_mkey != '0 && c.byte_length != '0;
      KIND_CMP_SWAP, KIND_FETCH_ADD: return c.remote_address != '0 && c.remote_mkey != '0;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void count_usage(logic [2:0] kind, logic [31:0] len);
    if (kind <= KIND_WRITE) begin
      usage_cnt[kind] += 64'd1;
      usage_cnt[BYTE_STATS + kind] += 64'(len);
    end else if (kind <= KIND_FETCH_ADD) begin
      usage_cnt[STAT_ATOMIC_OPS] += 64'd1;
    end
  endfunction

  function automatic qpwre_out_t execute_command(qpwre_in_t c);
    qpwre_out_t r;
    qpwre_send_ent_t se;
    qpwre_recv_ent_t re;
    r = '0;
    case (c.opcode)
      OP_TO_INIT: if (qp_state == ST_RESET) begin
        qp_state = ST_INIT;
        r.accepted = 1'b1;
      end
      OP_TO_RTR: if (qp_state == ST_INIT) begin
        qp_state = ST_RTR;
        r.accepted = 1'b1;
      end
      OP_TO_RTS: if (qp_state == ST_RTR) begin
        qp_state = ST_RTS;
        r.accepted = 1'b1;
      end
      OP_POST_SEND: if (qp_state == ST_RTS && request_well_formed(c.operation_kind, c)
                        && sq_cnt < sq_limit && sq_cnt < SEND_DEPTH) begin
        se.id = c.request_id;
        se.laddr = c.local_address;
        se.raddr = c.remote_address;
        se.lkey = c.local_mkey;
        se.rkey = c.remote_mkey;
        se.len = c.byte_length;
        se.kind = c.operation_kind;
        se.sig = c.signaled_flag;
        se.cmp = c.compare_or_add;
        se.swp = c.swap_value;
        sq_ent[(sq_head + sq_cnt) % SEND_DEPTH] = se;
        sq_cnt++;
        count_usage(c.operation_kind, c.byte_length);
        r.accepted = 1'b1;
      end
      OP_POST_RECV: if (qp_state == ST_RTS && request_well_formed(KIND_RECV, c)
                        && rq_cnt < rq_limit && rq_cnt < RECV_DEPTH) begin
        re.id = c.request_id;
        re.laddr = c.local_address;
        re.lkey = c.local_mkey;
        re.len = c.byte_length;
        rq_ent[(rq_head + rq_cnt) % RECV_DEPTH] = re;
        rq_cnt++;
        count_usage(KIND_RECV, c.byte_length);
        r.accepted = 1'b1;
      end
      OP_GET_SEND: if (sq_cnt != 0) begin
        se = sq_ent[sq_head];
        r.accepted = 1'b1;
        r.out_request_id = se.id;
        r.out_operation_kind = se.kind;
        r.out_local_address = se.laddr;
        r.out_local_mkey = se.lkey;
        r.out_remote_address = se.raddr;
        r.out_remote_mkey = se.rkey;
        r.out_byte_length = se.len;
        r.out_signaled = se.sig;
        r.out_compare_or_add = se.cmp;
        r.out_swap = se.swp;
        sq_head = (sq_head + 1) % SEND_DEPTH;
        sq_cnt--;
      end
      OP_GET_RECV: if (rq_cnt != 0) begin
        re = rq_ent[rq_head];
        r.accepted = 1'b1;
        r.out_request_id = re.id;
        r.out_operation_kind = KIND_RECV;
        r.out_local_address = re.laddr;
        r.out_local_mkey = re.lkey;
        r.out_byte_length = re.len;
        rq_head = (rq_head + 1) % RECV_DEPTH;
        rq_cnt--;
      end
      default: if (c.stat_index < STAT_NUM) begin
        r.stat_value = usage_cnt[c.stat_index];
        r.accepted = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic void apply_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    if (idx == CFG_SEND_LIMIT) sq_limit = int'(val);
    else if (idx == CFG_RECV_LIMIT) rq_limit = int'(val);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly nonzero, sometimes absent
  function automatic logic [63:0] rand_present();
    return ($urandom_range(24) == 0) ? 64'd0 : rand_word();
  endfunction

  function automatic qpwre_in_t make_cmd(logic [2:0] op, logic [2:0] kind);
    qpwre_in_t c;
    c.opcode = op;
    c.request_id = rand_word();
    c.operation_kind = kind;
    c.local_address = rand_word() | 64'd1;
    c.local_mkey = $urandom | 32'd1;
    c.remote_address = rand_word() | 64'd1;
    c.remote_mkey = $urandom | 32'd1;
    c.byte_length = $urandom_range(4096, 1);
    c.signaled_flag = 1'($urandom_range(1));
    c.compare_or_add = rand_word();
    c.swap_value = rand_word();
    c.stat_index = 4'($urandom_range(STAT_NUM - 1));
    return c;
  endfunction

  function automatic qpwre_in_t random_command(int post_pct);
    qpwre_in_t c;
    int r;
    c = make_cmd(OP_READ_STAT, 3'($urandom_range(5)));
    if ($urandom_range(15) == 0) c.operation_kind = 3'($urandom_range(7));
    c.local_address = rand_present();
    c.local_mkey = 32'(rand_present());
    c.remote_address = rand_present();
    c.remote_mkey = 32'(rand_present());
    case ($urandom_range(9))
      0: c.byte_length = '0;
      1: c.byte_length = $urandom;
      default: c.byte_length = $urandom_range(4096, 1);
    endcase
    if ($urandom_range(3) == 0) c.stat_index = 4'($urandom_range(15));
    r = $urandom_range(99);
    if (r < post_pct) begin
      c.opcode = ($urandom_range(4) < 3) ? OP_POST_SEND : OP_POST_RECV;
    end else begin
      r = $urandom_range(19);
      if (r < 8) c.opcode = OP_GET_SEND;
      else if (r < 14) c.opcode = OP_GET_RECV;
      else if (r < 18) c.opcode = OP_READ_STAT;
      else begin
        case ($urandom_range(2))
          0: c.opcode = OP_TO_INIT;
          1: c.opcode = OP_TO_RTR;
          default: c.opcode = OP_TO_RTS;
        endcase
      end
    end
    return c;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) flag_mismatch(what, want, got);
  endtask

  // command driver: predicts each beat as it is taken
  always @(posedge clk_i) begin : cmd_driver
    logic hold;
    if (rst_ni) begin
      hold = in_valid && !in_ready;
      if (in_valid && in_ready) wr_responses.push_back(execute_command(in_data));
      if (!hold) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
          in_data <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : resp_monitor
    qpwre_out_t want;
    qpwre_out_t got;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (wr_responses.size() == 0) begin
          flag_mismatch("unexpected response, accepted", 64'd0, 64'(got.accepted));
        end else begin
          want = wr_responses.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(got.accepted));
          check_field("request_id", want.out_request_id, got.out_request_id);
          check_field("operation_kind", 64'(want.out_operation_kind),
                      64'(got.out_operation_kind));
          check_field("local_address", want.out_local_address, got.out_local_address);
          check_field("local_mkey", 64'(want.out_local_mkey), 64'(got.out_local_mkey));
          check_field("remote_address", want.out_remote_address, got.out_remote_address);
          check_field("remote_mkey", 64'(want.out_remote_mkey), 64'(got.out_remote_mkey));
          check_field("byte_length", 64'(want.out_byte_length), 64'(got.out_byte_length));
          check_field("signaled", 64'(want.out_signaled), 64'(got.out_signaled));
          check_field("compare_or_add", want.out_compare_or_add, got.out_compare_or_add);
          check_field("swap", want.out_swap, got.out_swap);
          check_field("stat_value", want.stat_value, got.stat_value);
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || wr_responses.size() != 0)
      @(posedge clk_i);
    // pipeline is two deep, leave some slack
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    apply_limit(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(logic [LIMIT_W-1:0] s, logic [LIMIT_W-1:0] r);
    write_limit(CFG_SEND_LIMIT, s);
    write_limit(CFG_RECV_LIMIT, r);
  endtask

  task automatic run_phase(int n, int post_pct, bit no_idle);
    steady = no_idle;
    repeat (n) cmd_backlog.push_back(random_command(post_pct));
    drain();
  endtask

  initial begin : main_seq
    qpwre_in_t c;
    qp_state = ST_RESET;
    sq_head = 0;
    sq_cnt = 0;
    rq_head = 0;
    rq_cnt = 0;
    sq_limit = int'(LIMIT_RESET);
    rq_limit = int'(LIMIT_RESET);
    foreach (usage_cnt[i]) usage_cnt[i] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // state moves out of order, posts before rts, gets on empty queues
    cmd_backlog.push_back(make_cmd(OP_READ_STAT, KIND_SEND));
    cmd_backlog.push_back(make_cmd(OP_POST_SEND, KIND_SEND));
    cmd_backlog.push_back(make_cmd(OP_GET_SEND, KIND_SEND));
    cmd_backlog.push_back(make_cmd(OP_TO_RTR, KIND_SEND));
    cmd_backlog.push_back(make_cmd(OP_TO_RTS, KIND_SEND));
    cmd_backlog.push_back(make_cmd(OP_TO_INIT, KIND_SEND));
    cmd_backlog.push_back(make_cmd(OP_TO_INIT, KIND_SEND));
    cmd_backlog.push_back(make_cmd(OP_POST_RECV, KIND_RECV));
    cmd_backlog.push_back(make_cmd(OP_TO_RTR, KIND_SEND));
    cmd_backlog.push_back(make_cmd(OP_GET_RECV, KIND_RECV));
    cmd_backlog.push_back(make_cmd(OP_TO_RTS, KIND_SEND));
    c = '1;
    c.opcode = OP_POST_SEND;
    c.operation_kind = KIND_SEND;
    cmd_backlog.push_back(c);
    // a send-side post of a receive counts as a receive
    cmd_backlog.push_back(make_cmd(OP_POST_SEND, KIND_RECV));
    c = make_cmd(OP_POST_SEND, KIND_READ);
    c.remote_address = '0;
    cmd_backlog.push_back(c);
    cmd_backlog.push_back(make_cmd(OP_POST_SEND, KIND_WRITE));
    c = make_cmd(OP_POST_SEND, KIND_CMP_SWAP);
    c.byte_length = '0;
    cmd_backlog.push_back(c);
    cmd_backlog.push_back(make_cmd(OP_POST_SEND, KIND_FETCH_ADD));
    cmd_backlog.push_back(make_cmd(OP_POST_SEND, 3'($urandom_range(7, 6))));
    c = '0;
    c.opcode = OP_POST_SEND;
    cmd_backlog.push_back(c);
    c = make_cmd(OP_POST_RECV, KIND_RECV);
    c.byte_length = '0;
    cmd_backlog.push_back(c);
    c = '1;
    c.opcode = OP_POST_RECV;
    cmd_backlog.push_back(c);
    cmd_backlog.push_back(make_cmd(OP_GET_SEND, KIND_SEND));
    cmd_backlog.push_back(make_cmd(OP_GET_RECV, KIND_RECV));
    c = make_cmd(OP_READ_STAT, KIND_SEND);
    c.stat_index = '1;
    cmd_backlog.push_back(c);
    c.stat_index = STAT_ATOMIC_OPS;
    cmd_backlog.push_back(c);
    drain();

    run_phase(250, 45, 1'b0);
    set_limits(5'd0, 5'd16);
    run_phase(150, 50, 1'b0);
    set_limits(5'd16, 5'd0);
    write_limit(CFG_UNUSED, '1);
    run_phase(150, 50, 1'b0);
    set_limits(5'd3, 5'd5);
    run_phase(200, 60, 1'b1);
    set_limits(5'd31, 5'd1);
    run_phase(200, 55, 1'b0);
    set_limits(5'd16, 5'd16);
    // fill both queues to the top, then empty them
    run_phase(100, 85, 1'b0);
    run_phase(100, 10, 1'b0);

    if (mismatches == 0 && wr_responses.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/qpwre_pkg.sv
hdl/qpwre_ram.sv
hdl/qpwre_stats.sv
hdl/queue_pair_work_request_engine.sv
tb/queue_pair_work_request_engine_test.sv
